// ----- rtl/czsa_pkg.sv -----
// shared types and constants of the crop-zoom source address generator
`timescale 1ns / 1ps
`default_nettype none
package czsa_pkg;

  localparam int unsigned MAX_DIM    = 4096;
  localparam int unsigned POS_W      = 17;
  localparam int unsigned ZOOM_W     = 19;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned INDEX_W    = 24;
  localparam int unsigned CROP_W     = 18;
  localparam int unsigned REM_W      = 19;
  localparam int unsigned DIV_STAGES = CROP_W;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [POS_W-1:0]  ONE_Q16  = POS_W'(65536);
  localparam logic [ZOOM_W-1:0] ZOOM_MIN = ZOOM_W'(32768);
  localparam logic [ZOOM_W-1:0] ZOOM_MAX = ZOOM_W'(262144);
  // 2^32 shifted down by the quotient width: partial remainder before the first bit
  localparam logic [REM_W-1:0]  DIV_SEED = REM_W'(64'h1_0000_0000 >> CROP_W);
  localparam logic [DIM_W-1:0]  DIM_MAX  = DIM_W'(MAX_DIM);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAN_X_START = 3'd0,
    REG_PAN_X_END   = 3'd1,
    REG_PAN_Y_START = 3'd2,
    REG_PAN_Y_END   = 3'd3,
    REG_ZOOM_BEGIN  = 3'd4,
    REG_ZOOM_FINISH = 3'd5,
    REG_FRAME_W     = 3'd6,
    REG_FRAME_H     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [POS_W-1:0]   progress;
    logic [COORD_W-1:0] dest_col;
    logic [COORD_W-1:0] dest_row;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] src_col;
    logic [COORD_W-1:0] src_row;
    logic [INDEX_W-1:0] src_pixel_index;
  } result_t;

  // payload that rides alongside the crop divider
  typedef struct packed {
    logic [POS_W-1:0]   cx;
    logic [POS_W-1:0]   cy;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } side_t;

endpackage
`default_nettype wire

// ----- rtl/crop_zoom_source_address.sv -----
// top level: pan-and-zoom source address generator, one destination pixel per clock
// path: stages 0 to 2, the crop divider, then stages 3 to 7; stage 7 registers done_o and the result
// throughput: one item per clock, busy_o stays low; the 18-stage crop divider sets the depth
// results cannot be held off by the receiver, so the pipeline never stalls
// reset: asynchronous, active low; clears all valid bits and loads register defaults
`timescale 1ns / 1ps
`default_nettype none
module crop_zoom_source_address (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  czsa_pkg::in_item_t             in_item_i,
  output logic                           done_o,
  output czsa_pkg::result_t              result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [czsa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [czsa_pkg::ZOOM_W-1:0]    cfg_data_i
);
  import czsa_pkg::*;

  // configuration registers
  logic [POS_W-1:0]  pan_x_start_q, pan_x_end_q, pan_y_start_q, pan_y_end_q;
  logic [ZOOM_W-1:0] zoom_begin_q, zoom_finish_q;
  logic [DIM_W-1:0]  frame_w_q, frame_h_q;

  // registers always accept a write; index covers exactly the eight registers
  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_x_start_q <= POS_W'(32768);
      pan_x_end_q   <= POS_W'(32768);
      pan_y_start_q <= POS_W'(32768);
      pan_y_end_q   <= POS_W'(32768);
      zoom_begin_q  <= ZOOM_W'(65536);
      zoom_finish_q <= ZOOM_W'(65536);
      frame_w_q     <= DIM_W'(1024);
      frame_h_q     <= DIM_W'(576);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PAN_X_START: pan_x_start_q <= cfg_data_i[POS_W-1:0];
        REG_PAN_X_END:   pan_x_end_q   <= cfg_data_i[POS_W-1:0];
        REG_PAN_Y_START: pan_y_start_q <= cfg_data_i[POS_W-1:0];
        REG_PAN_Y_END:   pan_y_end_q   <= cfg_data_i[POS_W-1:0];
        REG_ZOOM_BEGIN:  zoom_begin_q  <= cfg_data_i;
        REG_ZOOM_FINISH: zoom_finish_q <= cfg_data_i;
        REG_FRAME_W:     frame_w_q     <= cfg_data_i[DIM_W-1:0];
        REG_FRAME_H:     frame_h_q     <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size: zero acts as one, anything above the maximum saturates
  logic [DIM_W-1:0] w_eff, h_eff;
  assign w_eff = (frame_w_q == '0) ? DIM_W'(1) : ((frame_w_q > DIM_MAX) ? DIM_MAX : frame_w_q);
  assign h_eff = (frame_h_q == '0) ? DIM_W'(1) : ((frame_h_q > DIM_MAX) ? DIM_MAX : frame_h_q);

  // ---------------- stage 0: capture, saturate progress at one
  logic               v0_q;
  logic [POS_W-1:0]   p0_q;
  logic [COORD_W-1:0] col0_q, row0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q   <= (in_item_i.progress > ONE_Q16) ? ONE_Q16 : in_item_i.progress;
    col0_q <= in_item_i.dest_col;
    row0_q <= in_item_i.dest_row;
  end

  // ---------------- stage 1: interpolation products (end - start) * progress
  logic signed [POS_W:0]    dx, dy;
  logic signed [ZOOM_W:0]   dz;
  logic signed [POS_W:0]    ps;
  logic signed [35:0]       px_d, py_d;
  logic signed [37:0]       pz_d;
  logic signed [35:0]       px_q, py_q;
  logic signed [37:0]       pz_q;
  logic                     v1_q;
  logic [COORD_W-1:0]       col1_q, row1_q;

  assign ps   = $signed({1'b0, p0_q});
  assign dx   = $signed({1'b0, pan_x_end_q}) - $signed({1'b0, pan_x_start_q});
  assign dy   = $signed({1'b0, pan_y_end_q}) - $signed({1'b0, pan_y_start_q});
  assign dz   = $signed({1'b0, zoom_finish_q}) - $signed({1'b0, zoom_begin_q});
  assign px_d = dx * ps;
  assign py_d = dy * ps;
  assign pz_d = dz * ps;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    pz_q   <= pz_d;
    col1_q <= col0_q;
    row1_q <= row0_q;
  end

  // ---------------- stage 2: start + floor(product / 2^16), then clamp
  logic signed [35:0] shx, shy;
  logic signed [37:0] shz;
  logic signed [21:0] lx, ly, lz;
  logic [POS_W-1:0]   cx_d, cy_d;
  logic [ZOOM_W-1:0]  zoom_d;
  logic               v2_q;
  logic [ZOOM_W-1:0]  zoom2_q;
  side_t              side2_q;

  assign shx = px_q >>> 16;
  assign shy = py_q >>> 16;
  assign shz = pz_q >>> 16;
  assign lx  = $signed({5'b0, pan_x_start_q}) + $signed(shx[21:0]);
  assign ly  = $signed({5'b0, pan_y_start_q}) + $signed(shy[21:0]);
  assign lz  = $signed({3'b0, zoom_begin_q}) + $signed(shz[21:0]);

  always_comb begin
    if (lx < 0) begin
      cx_d = '0;
    end else if (lx > $signed({5'b0, ONE_Q16})) begin
      cx_d = ONE_Q16;
    end else begin
      cx_d = lx[POS_W-1:0];
    end
    if (ly < 0) begin
      cy_d = '0;
    end else if (ly > $signed({5'b0, ONE_Q16})) begin
      cy_d = ONE_Q16;
    end else begin
      cy_d = ly[POS_W-1:0];
    end
    if (lz < $signed({3'b0, ZOOM_MIN})) begin
      zoom_d = ZOOM_MIN;
    end else if (lz > $signed({3'b0, ZOOM_MAX})) begin
      zoom_d = ZOOM_MAX;
    end else begin
      zoom_d = lz[ZOOM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    zoom2_q     <= zoom_d;
    side2_q.cx  <= cx_d;
    side2_q.cy  <= cy_d;
    side2_q.col <= col1_q;
    side2_q.row <= row1_q;
  end

  // ---------------- crop size divider, one quotient bit per stage
  logic              vdiv;
  logic [CROP_W-1:0] crop_div;
  side_t             side_div;

  czsa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .zoom_i  (zoom2_q),
    .side_i  (side2_q),
    .valid_o (vdiv),
    .crop_o  (crop_div),
    .side_o  (side_div)
  );

  // ---------------- stage 3: crop origin, kept inside the frame
  logic [POS_W-1:0]   half, lim, ox_d, oy_d;
  logic               v3_q;
  logic [POS_W-1:0]   ox3_q, oy3_q;
  logic [CROP_W-1:0]  crop3_q;
  logic [COORD_W-1:0] col3_q, row3_q;

  assign half = crop_div[CROP_W-1:1];
  assign lim  = ONE_Q16 - crop_div[POS_W-1:0];

  always_comb begin
    ox_d = (side_div.cx > half) ? side_div.cx - half : '0;
    oy_d = (side_div.cy > half) ? side_div.cy - half : '0;
    if (crop_div >= CROP_W'(ONE_Q16)) begin
      // crop covers the whole frame or more
      ox_d = '0;
      oy_d = '0;
    end else begin
      if (ox_d > lim) ox_d = lim;
      if (oy_d > lim) oy_d = lim;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= vdiv;
    end
  end

  always_ff @(posedge clk_i) begin
    ox3_q   <= ox_d;
    oy3_q   <= oy_d;
    crop3_q <= crop_div;
    col3_q  <= side_div.col;
    row3_q  <= side_div.row;
  end

  // ---------------- stage 4: origin * dim and coord * crop
  logic        v4_q;
  logic [29:0] mox_q, moy_q, mcx_q, mcy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mox_q <= 30'(ox3_q) * 30'(w_eff);
    moy_q <= 30'(oy3_q) * 30'(h_eff);
    mcx_q <= 30'(col3_q) * 30'(crop3_q);
    mcy_q <= 30'(row3_q) * 30'(crop3_q);
  end

  // ---------------- stage 5: sum, drop the fraction, clamp to the last column or row
  logic [30:0]        sumx, sumy;
  logic [COORD_W-1:0] wlim, hlim, sc_d, sr_d;
  logic               v5_q;
  logic [COORD_W-1:0] sc5_q, sr5_q;

  assign sumx = {1'b0, mox_q} + {1'b0, mcx_q};
  assign sumy = {1'b0, moy_q} + {1'b0, mcy_q};
  assign wlim = COORD_W'(w_eff - DIM_W'(1));
  assign hlim = COORD_W'(h_eff - DIM_W'(1));
  assign sc_d = (sumx[30:16] > {3'b0, wlim}) ? wlim : sumx[16+COORD_W-1:16];
  assign sr_d = (sumy[30:16] > {3'b0, hlim}) ? hlim : sumy[16+COORD_W-1:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sc5_q <= sc_d;
    sr5_q <= sr_d;
  end

  // ---------------- stage 6: row * width
  logic [INDEX_W:0]   rw_d;
  logic               v6_q;
  logic [INDEX_W-1:0] rw6_q;
  logic [COORD_W-1:0] sc6_q, sr6_q;

  assign rw_d = (INDEX_W+1)'(sr5_q) * (INDEX_W+1)'(w_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rw6_q <= rw_d[INDEX_W-1:0];
    sc6_q <= sc5_q;
    sr6_q <= sr5_q;
  end

  // ---------------- stage 7: output register, linear index
  logic    done_q;
  result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.src_col         <= sc6_q;
    res_q.src_row         <= sr6_q;
    res_q.src_pixel_index <= rw6_q + INDEX_W'(sc6_q);
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

// ----- rtl/czsa_div.sv -----
// pipelined restoring divider: crop = floor(2^32 / zoom), one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module czsa_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [czsa_pkg::ZOOM_W-1:0]   zoom_i,
  input  czsa_pkg::side_t               side_i,
  output logic                          valid_o,
  output logic [czsa_pkg::CROP_W-1:0]   crop_o,
  output czsa_pkg::side_t               side_o
);
  import czsa_pkg::*;

  logic                valid_q [DIV_STAGES];
  logic [REM_W-1:0]    rem_q   [DIV_STAGES];
  logic [CROP_W-1:0]   quo_q   [DIV_STAGES];
  logic [ZOOM_W-1:0]   div_q   [DIV_STAGES];
  side_t               side_q  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic              vin;
    logic [REM_W-1:0]  rem_in;
    logic [CROP_W-1:0] quo_in;
    logic [ZOOM_W-1:0] div_in;
    side_t             side_in;
    logic [REM_W:0]    trial;
    logic [REM_W:0]    diff;
    logic              take;

    if (k == 0) begin : g_first
      assign vin     = valid_i;
      assign rem_in  = DIV_SEED;
      assign quo_in  = '0;
      assign div_in  = zoom_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vin     = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign div_in  = div_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, 1'b0};
    assign diff  = trial - {1'b0, div_in};
    assign take  = (trial >= {1'b0, div_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= take ? diff[REM_W-1:0] : trial[REM_W-1:0];
      quo_q[k]  <= {quo_in[CROP_W-2:0], take};
      div_q[k]  <= div_in;
      side_q[k] <= side_in;
    end
  end

  assign valid_o = valid_q[DIV_STAGES-1];
  assign crop_o  = quo_q[DIV_STAGES-1];
  assign side_o  = side_q[DIV_STAGES-1];

endmodule
`default_nettype wire

// ----- rtl/czsa_checker.sv -----
// port-level checker for the crop-zoom source address generator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module czsa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           done_o,
  input czsa_pkg::result_t              result_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o
);
  import czsa_pkg::*;

  // every accepted item comes out after the fixed pipeline depth
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##26 done_o)
    else $error("item did not complete after pipeline depth");

  // the pipeline never refuses an item
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("busy raised");

  // index is row * width + col with width at least one, so it is never below row plus column
  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.src_pixel_index >=
               (INDEX_W'(result_o.src_col) + INDEX_W'(result_o.src_row))))
    else $error("pixel index below row plus column");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("register write refused");

endmodule

bind crop_zoom_source_address czsa_checker u_czsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .result_o    (result_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
`default_nettype wire
